// ----- rtl/g2h_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// g2h_pkg: shared types and constants for the Gregorian to Hijri converter
// Field widths, status and register codes, day-number constants and the
// request item that travels from the front end to the table walker.
// ----------------------------------------------------------------------------
package g2h_pkg;

    localparam int TABLE_BYTES_DEFAULT = 64;
    localparam int QUEUE_DEPTH         = 2;

    // request / response field widths
    localparam int INDEX_W  = 6;
    localparam int BYTE_W   = 8;
    localparam int GYEAR_W  = 14;
    localparam int GMONTH_W = 4;
    localparam int GDAY_W   = 5;
    localparam int HDAY_W   = 5;
    localparam int HMONTH_W = 4;
    localparam int HYEAR_W  = 12;
    localparam int STATUS_W = 2;

    // configuration port
    localparam int REF_W       = 22;
    localparam int OFFSET_W    = 10;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 22;

    // day-number datapath
    localparam int YEAR_W   = 15;           // greg_year + 4800
    localparam int QTR_W    = YEAR_W - 2;   // year / 4
    localparam int MSTART_W = 9;
    localparam int SUM_W    = 24;
    localparam int PROD_W   = 25;
    localparam int QUOT_W   = 8;            // year / 100
    localparam int DAYS_W   = 25;           // signed day count

    localparam int YEAR_BIAS       = 4800;
    localparam int DAY_BASE        = 32045;
    localparam int DAYS_PER_YEAR   = 365;
    localparam int MARCH           = 3;
    localparam int MONTHS_PER_YEAR = 12;
    // floor(x / 25) = (x * RECIP_25) >> RECIP_SHIFT for x < 43690
    localparam int RECIP_25        = 5243;
    localparam int RECIP_SHIFT     = 17;

    localparam int SHORT_MONTH   = 29;
    localparam int LONG_MONTH    = 30;
    localparam int BITS_PER_BYTE = 8;

    // (153 * m + 2) / 5 for months counted from March
    localparam logic [MSTART_W-1:0] MONTH_START_DAYS [16] = '{
        9'd0,   9'd31,  9'd61,  9'd92,  9'd122, 9'd153, 9'd184, 9'd214,
        9'd245, 9'd275, 9'd306, 9'd337, 9'd367, 9'd0,   9'd0,   9'd0
    };

    localparam logic [REF_W-1:0]    RESET_REFERENCE_DAY = 22'd2451516;
    localparam logic [OFFSET_W-1:0] RESET_DAY_OFFSET    = 10'd0;
    localparam logic [HYEAR_W-1:0]  RESET_START_YEAR    = 12'd1420;
    localparam logic [HMONTH_W-1:0] RESET_START_MONTH   = 4'd8;

    typedef enum logic {
        ACT_LOAD    = 1'b0,
        ACT_CONVERT = 1'b1
    } g2h_action_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_CONVERTED = 2'd0,
        STATUS_LOADED    = 2'd1,
        STATUS_PAST_END  = 2'd2
    } g2h_status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_REFERENCE_DAY = 2'd0,
        CFG_DAY_OFFSET    = 2'd1,
        CFG_START_YEAR    = 2'd2,
        CFG_START_MONTH   = 2'd3
    } g2h_cfg_index_t;

    typedef struct packed {
        logic [REF_W-1:0]    reference_day_number;
        logic [OFFSET_W-1:0] day_offset;
        logic [HYEAR_W-1:0]  start_year;
        logic [HMONTH_W-1:0] start_month;
    } g2h_cfg_t;

    // classified request: a table load or a conversion with its day count
    typedef struct packed {
        logic               convert;
        logic [INDEX_W-1:0] index;
        logic [BYTE_W-1:0]  data;
        logic [DAYS_W-1:0]  days;
    } g2h_item_t;

endpackage
`default_nettype wire

// ----- rtl/g2h_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// g2h_req_if: request channel
// Table loads and date conversions with valid/ready handshake.
// ----------------------------------------------------------------------------
interface g2h_req_if import g2h_pkg::*; ();

    logic                valid;
    logic                ready;
    logic                action;
    logic [INDEX_W-1:0]  table_index;
    logic [BYTE_W-1:0]   table_byte;
    logic [GYEAR_W-1:0]  greg_year;
    logic [GMONTH_W-1:0] greg_month;
    logic [GDAY_W-1:0]   greg_day;

    modport source (
        output valid, action, table_index, table_byte, greg_year, greg_month, greg_day,
        input  ready
    );

    modport sink (
        input  valid, action, table_index, table_byte, greg_year, greg_month, greg_day,
        output ready
    );

endinterface
`default_nettype wire

// ----- rtl/g2h_rsp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// g2h_rsp_if: response channel
// Hijri date and status with valid/ready handshake.
// ----------------------------------------------------------------------------
interface g2h_rsp_if import g2h_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [HDAY_W-1:0]   hijri_day;
    logic [HMONTH_W-1:0] hijri_month;
    logic [HYEAR_W-1:0]  hijri_year;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, hijri_day, hijri_month, hijri_year, status,
        input  ready
    );

    modport sink (
        input  valid, hijri_day, hijri_month, hijri_year, status,
        output ready
    );

endinterface
`default_nettype wire

// ----- rtl/g2h_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// g2h_front: request front end
// Three-stage pipeline that classifies each request and, for conversions,
// forms the day count: Julian day number - reference day + offset.
// ----------------------------------------------------------------------------
module g2h_front import g2h_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    g2h_req_if.sink        req,
    input  wire g2h_cfg_t  cfg,
    output logic           push_valid,
    output g2h_item_t      push_item,
    input  wire logic      push_ready
);

    logic advance;

    // stage 1
    logic                p1_valid_reg;
    logic                p1_convert_reg;
    logic [INDEX_W-1:0]  p1_index_reg;
    logic [BYTE_W-1:0]   p1_data_reg;
    logic [YEAR_W-1:0]   p1_year_reg;
    logic [QTR_W-1:0]    p1_quarter_reg;
    logic [MSTART_W-1:0] p1_mstart_reg;
    logic [GDAY_W-1:0]   p1_day_reg;
    logic [DAYS_W-1:0]   p1_bias_reg;

    logic                early;
    logic [YEAR_W-1:0]   p1_year_next;
    logic [GMONTH_W-1:0] p1_march_month;
    logic [DAYS_W-1:0]   p1_bias_next;

    // stage 2
    logic                p2_valid_reg;
    logic                p2_convert_reg;
    logic [INDEX_W-1:0]  p2_index_reg;
    logic [BYTE_W-1:0]   p2_data_reg;
    logic [SUM_W-1:0]    p2_sum_reg;
    logic [QUOT_W-1:0]   p2_cent_reg;
    logic [DAYS_W-1:0]   p2_bias_reg;

    logic [SUM_W-1:0]    p2_sum_next;
    logic [PROD_W-1:0]   p2_prod;

    // stage 3
    logic                p3_valid_reg;
    g2h_item_t           p3_item_reg;
    logic [DAYS_W-1:0]   p3_days_next;

    assign advance   = !p3_valid_reg || push_ready;
    assign req.ready = advance;

    // Jan and Feb count as months 11 and 12 of the previous year
    always_comb
    begin
        early          = req.greg_month < GMONTH_W'(MARCH);
        p1_year_next   = YEAR_W'(req.greg_year) + YEAR_W'(YEAR_BIAS) - YEAR_W'(early);
        p1_march_month = early ? req.greg_month + GMONTH_W'(MONTHS_PER_YEAR - MARCH)
                               : req.greg_month - GMONTH_W'(MARCH);
        p1_bias_next   = DAYS_W'($signed(cfg.day_offset))
                         - DAYS_W'(cfg.reference_day_number) - DAYS_W'(DAY_BASE);
    end

    always_comb
    begin
        p2_sum_next = SUM_W'(p1_year_reg) * SUM_W'(DAYS_PER_YEAR)
                      + SUM_W'(p1_mstart_reg) + SUM_W'(p1_day_reg)
                      + SUM_W'(p1_quarter_reg);
        p2_prod     = PROD_W'(p1_quarter_reg) * PROD_W'(RECIP_25);
    end

    // y/100 - y/400 folded in, all modulo 2^DAYS_W
    assign p3_days_next = DAYS_W'(p2_sum_reg) - DAYS_W'(p2_cent_reg)
                          + DAYS_W'(p2_cent_reg[QUOT_W-1:2]) + p2_bias_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            p1_valid_reg <= req.valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p1_convert_reg <= (req.action == ACT_CONVERT);
            p1_index_reg   <= req.table_index;
            p1_data_reg    <= req.table_byte;
            p1_year_reg    <= p1_year_next;
            p1_quarter_reg <= p1_year_next[YEAR_W-1:2];
            p1_mstart_reg  <= MONTH_START_DAYS[p1_march_month];
            p1_day_reg     <= req.greg_day;
            p1_bias_reg    <= p1_bias_next;

            p2_convert_reg <= p1_convert_reg;
            p2_index_reg   <= p1_index_reg;
            p2_data_reg    <= p1_data_reg;
            p2_sum_reg     <= p2_sum_next;
            p2_cent_reg    <= p2_prod[RECIP_SHIFT +: QUOT_W];
            p2_bias_reg    <= p1_bias_reg;

            p3_item_reg.convert <= p2_convert_reg;
            p3_item_reg.index   <= p2_index_reg;
            p3_item_reg.data    <= p2_data_reg;
            p3_item_reg.days    <= p3_days_next;
        end
    end

    assign push_valid = p3_valid_reg;
    assign push_item  = p3_item_reg;

endmodule
`default_nettype wire

// ----- rtl/g2h_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// g2h_queue: request queue
// Short FIFO between the front end and the table walker.
// ----------------------------------------------------------------------------
module g2h_queue import g2h_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push_valid,
    input  wire g2h_item_t  push_item,
    output logic            push_ready,
    output logic            pop_valid,
    output g2h_item_t       pop_item,
    input  wire logic       pop_ready
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    g2h_item_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/g2h_walk.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// g2h_walk: month table walker
// Holds the month-length bitmap, applies table loads and drives the response
// register; conversions walk the bitmap one month per cycle between fetches.
// ----------------------------------------------------------------------------
module g2h_walk import g2h_pkg::*; #(
    parameter int TABLE_BYTES = TABLE_BYTES_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire g2h_cfg_t   cfg,
    input  wire logic       pop_valid,
    input  wire g2h_item_t  pop_item,
    output logic            pop_ready,
    g2h_rsp_if.source       rsp,
    output logic            idle
);

    localparam int AW     = (TABLE_BYTES > 1) ? $clog2(TABLE_BYTES) : 1;
    localparam int BC_W   = $clog2(TABLE_BYTES + 1);
    localparam int WIDE_W = AW + INDEX_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_FETCH  = 4'b0010,
        ST_WALK   = 4'b0100,
        ST_FINISH = 4'b1000
    } walk_state_t;

    walk_state_t          state_reg, state_next;
    logic [BC_W-1:0]      byte_cnt_reg, byte_cnt_next;
    logic [2:0]           bit_cnt_reg, bit_cnt_next;
    logic signed [DAYS_W-1:0] days_reg, days_next;
    logic [HMONTH_W-1:0]  month_reg, month_next;
    logic [HYEAR_W-1:0]   year_reg, year_next;
    logic                 past_end_reg, past_end_next;

    logic                 out_valid_reg, out_valid_next;
    logic [HDAY_W-1:0]    out_day_reg, out_day_next;
    logic [HMONTH_W-1:0]  out_month_reg, out_month_next;
    logic [HYEAR_W-1:0]   out_year_reg, out_year_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;

    logic [BYTE_W-1:0]    mem [TABLE_BYTES];
    logic [BYTE_W-1:0]    rd_data_reg;
    logic                 wr_en;
    logic [WIDE_W-1:0]    wr_wide;
    logic                 load_in_range;

    logic                 slot_free;
    logic                 cur_long;
    logic signed [DAYS_W-1:0] month_len;
    logic                 consume;
    logic [BC_W-1:0]      byte_inc;

    assign slot_free     = !out_valid_reg || rsp.ready;
    assign load_in_range = 32'(pop_item.index) < TABLE_BYTES;
    assign wr_wide       = WIDE_W'(pop_item.index);
    assign wr_en         = (state_reg == ST_IDLE) && pop_valid && !pop_item.convert
                           && slot_free && load_in_range;

    // bit 7 of each byte is the earliest month
    assign cur_long  = rd_data_reg[~bit_cnt_reg];
    assign month_len = cur_long ? DAYS_W'(LONG_MONTH) : DAYS_W'(SHORT_MONTH);
    assign consume   = days_reg >= month_len;
    assign byte_inc  = byte_cnt_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_wide[AW-1:0]] <= pop_item.data;
        end
        rd_data_reg <= mem[byte_cnt_reg[AW-1:0]];
    end

    always_comb
    begin
        state_next      = state_reg;
        byte_cnt_next   = byte_cnt_reg;
        bit_cnt_next    = bit_cnt_reg;
        days_next       = days_reg;
        month_next      = month_reg;
        year_next       = year_reg;
        past_end_next   = past_end_reg;
        pop_ready       = 1'b0;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_day_next    = out_day_reg;
        out_month_next  = out_month_reg;
        out_year_next   = out_year_reg;
        out_status_next = out_status_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    if (!pop_item.convert)
                    begin
                        if (slot_free)
                        begin
                            pop_ready       = 1'b1;
                            out_valid_next  = 1'b1;
                            out_day_next    = '0;
                            out_month_next  = '0;
                            out_year_next   = '0;
                            out_status_next = STATUS_LOADED;
                        end
                    end
                    else
                    begin
                        pop_ready     = 1'b1;
                        days_next     = $signed(pop_item.days);
                        month_next    = cfg.start_month;
                        year_next     = cfg.start_year;
                        byte_cnt_next = '0;
                        bit_cnt_next  = '0;
                        past_end_next = 1'b0;
                        state_next    = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (consume)
                begin
                    days_next    = days_reg - month_len;
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                    // out-of-range start months also wrap to 1 here
                    if (month_reg >= HMONTH_W'(MONTHS_PER_YEAR))
                    begin
                        month_next = HMONTH_W'(1);
                        year_next  = year_reg + 1'b1;
                    end
                    else
                    begin
                        month_next = month_reg + 1'b1;
                    end
                    if (bit_cnt_reg == 3'(BITS_PER_BYTE - 1))
                    begin
                        byte_cnt_next = byte_inc;
                        if (byte_inc == BC_W'(TABLE_BYTES))
                        begin
                            past_end_next = 1'b1;
                            state_next    = ST_FINISH;
                        end
                        else
                        begin
                            state_next = ST_FETCH;
                        end
                    end
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (days_reg < 0)
                    begin
                        out_day_next = HDAY_W'(1);
                    end
                    else if (days_reg >= DAYS_W'(SHORT_MONTH))
                    begin
                        out_day_next = HDAY_W'(LONG_MONTH);
                    end
                    else
                    begin
                        out_day_next = days_reg[HDAY_W-1:0] + 1'b1;
                    end
                    if (month_reg == '0)
                    begin
                        out_month_next = HMONTH_W'(1);
                    end
                    else if (month_reg > HMONTH_W'(MONTHS_PER_YEAR))
                    begin
                        out_month_next = HMONTH_W'(MONTHS_PER_YEAR);
                    end
                    else
                    begin
                        out_month_next = month_reg;
                    end
                    out_year_next   = year_reg;
                    out_status_next = past_end_reg ? STATUS_PAST_END : STATUS_CONVERTED;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            byte_cnt_reg  <= '0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            byte_cnt_reg  <= byte_cnt_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        days_reg       <= days_next;
        month_reg      <= month_next;
        year_reg       <= year_next;
        past_end_reg   <= past_end_next;
        out_day_reg    <= out_day_next;
        out_month_reg  <= out_month_next;
        out_year_reg   <= out_year_next;
        out_status_reg <= out_status_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.hijri_day   = out_day_reg;
    assign rsp.hijri_month = out_month_reg;
    assign rsp.hijri_year  = out_year_reg;
    assign rsp.status      = out_status_reg;
    assign idle            = state_reg == ST_IDLE;

endmodule
`default_nettype wire

// ----- rtl/gregorian_to_hijri_table_walk_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gregorian_to_hijri_table_walk_core: Gregorian to Hijri date converter
// Requests on req either load one byte of the month-length bitmap
// (action 0) or convert a Gregorian date (action 1); every request gives
// exactly one response on rsp, in request order. The user must write
// registers on cfg_we/cfg_index/cfg_data only while no request is in
// flight; the block does not enforce this. A three-stage front end forms
// the day count and feeds a two-entry queue; the walker behind it applies
// loads and walks the bitmap. A load's response passes the front end
// stages, the queue and the output register; a conversion's also passes
// the fetch, walk and finish states, a walk step per month and a fetch per
// further byte. The walk, one month per cycle apart from fetches, sets the
// conversion rate; loads stream at one per cycle while rsp is ready.
// Reset clears the handshake state and restores register defaults; the
// bitmap is not cleared and must be loaded before it is walked.
// When rsp stalls the result holds in its output register while the
// front end and queue keep taking requests until the queue and the last front-end stage hold requests.
// ----------------------------------------------------------------------------
module gregorian_to_hijri_table_walk_core import g2h_pkg::*; #(
    parameter int TABLE_BYTES = TABLE_BYTES_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    g2h_req_if.sink                     req,
    g2h_rsp_if.source                   rsp
);

    g2h_cfg_t  cfg_reg;
    logic      q_push_valid, q_push_ready;
    g2h_item_t q_push_item;
    logic      q_pop_valid, q_pop_ready;
    g2h_item_t q_pop_item;
    logic      walk_idle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reference_day_number <= RESET_REFERENCE_DAY;
            cfg_reg.day_offset           <= RESET_DAY_OFFSET;
            cfg_reg.start_year           <= RESET_START_YEAR;
            cfg_reg.start_month          <= RESET_START_MONTH;
        end
        else if (cfg_we)
        begin
            unique case (g2h_cfg_index_t'(cfg_index))
                CFG_REFERENCE_DAY: cfg_reg.reference_day_number <= cfg_data[REF_W-1:0];
                CFG_DAY_OFFSET:    cfg_reg.day_offset           <= cfg_data[OFFSET_W-1:0];
                CFG_START_YEAR:    cfg_reg.start_year           <= cfg_data[HYEAR_W-1:0];
                CFG_START_MONTH:   cfg_reg.start_month          <= cfg_data[HMONTH_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    g2h_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg        (cfg_reg),
        .push_valid (q_push_valid),
        .push_item  (q_push_item),
        .push_ready (q_push_ready)
    );

    g2h_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_item  (q_push_item),
        .push_ready (q_push_ready),
        .pop_valid  (q_pop_valid),
        .pop_item   (q_pop_item),
        .pop_ready  (q_pop_ready)
    );

    g2h_walk #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (q_pop_valid),
        .pop_item  (q_pop_item),
        .pop_ready (q_pop_ready),
        .rsp       (rsp),
        .idle      (walk_idle)
    );

`ifndef SYNTH
    // load responses carry no date
    a_load_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == STATUS_LOADED) |->
        (rsp.hijri_day == '0 && rsp.hijri_month == '0 && rsp.hijri_year == '0))
        else $error("load response with nonzero date fields");

    // conversion responses are clamped into a legal date
    a_conv_fields_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != STATUS_LOADED) |->
        ((rsp.status == STATUS_CONVERTED || rsp.status == STATUS_PAST_END)
         && rsp.hijri_day >= HDAY_W'(1) && rsp.hijri_day <= HDAY_W'(LONG_MONTH)
         && rsp.hijri_month >= HMONTH_W'(1)
         && rsp.hijri_month <= HMONTH_W'(MONTHS_PER_YEAR)))
        else $error("conversion response out of range");

    // an idle walker with nothing queued cannot produce a response
    a_no_spurious_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (walk_idle && !q_pop_valid && (!rsp.valid || rsp.ready)) |=> !rsp.valid)
        else $error("response without a queued request");
`endif

endmodule
`default_nettype wire
